// ===== design/sosc_pkg.sv =====
// Package for the sine oscillator core: widths, register indexes, reset values,
// the config struct, the stage struct and the quarter-wave sine table builder.
// No dependencies.
`default_nettype none

package sosc_pkg;

  localparam int SINE_TABLE_BITS = 8;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
  localparam int ROM_DIV         = 2 * TABLE_SIZE;

  localparam int NOTE_W        = 19;
  localparam int OFFSET_W      = 14;
  localparam int SAMPLE_W      = 16;
  localparam int SINE_W        = 16;
  localparam int PHASE_STEP_W  = 24;
  localparam int AMP_STEP_W    = 20;
  localparam int AMP_W         = 24;
  localparam int CFG_W         = 24;
  localparam int CFG_INDEX_W   = 2;
  localparam int PROD_W        = NOTE_W + PHASE_STEP_W;
  localparam int MAG_W         = SINE_W + AMP_W;

  // the product is a 2^40 turn: rescale to the accumulator width
  localparam int RSHIFT = (PHASE_BITS <= 40) ? (40 - PHASE_BITS) : 0;
  localparam int LSHIFT = (PHASE_BITS > 40) ? (PHASE_BITS - 40) : 0;

  localparam logic [NOTE_W-1:0] FREQ_MIN = 19'd320;
  localparam logic [NOTE_W-1:0] FREQ_MAX = 19'd320000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMP_STEP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AMP_LIMIT  = 2'd2;

  localparam logic [PHASE_STEP_W-1:0] RESET_PHASE_STEP = 24'd1431655;
  localparam logic [AMP_STEP_W-1:0]   RESET_AMP_STEP   = 20'd1678;
  localparam logic [AMP_W-1:0]        RESET_AMP_LIMIT  = 24'd12582912;

  typedef struct packed {
    logic [PHASE_STEP_W-1:0] phase_step;
    logic [AMP_STEP_W-1:0]   amp_step;
    logic [AMP_W-1:0]        amp_limit;
  } cfg_t;

  // word handed from the state/lookup stage to the scaling stage
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [SINE_W-1:0] sine;
    logic [AMP_W-1:0]  amp;
  } stage_c_t;

  typedef logic [SINE_W-1:0] sine_rom_t [TABLE_SIZE];

  // entry k = sin((k + 1/2) * pi / (2 * TABLE_SIZE)) in Q15, Taylor series in Q30
  function automatic sine_rom_t build_sine_table();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      x    = (64'(2 * k + 1) * HALF_PI_Q30) / ROM_DIV;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          default: term = term / 156;
        endcase
        if ((n & 1) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + 64'd16384) >> 15;
      rom[k] = (r > 64'd32767) ? 16'd32767 : r[SINE_W-1:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ===== design/sosc_if.sv =====
// Handshake interfaces for the oscillator: tick words in, stereo sample words out.
// Depends on sosc_pkg.
`default_nettype none

interface sosc_tick_if;
  logic                                  valid;
  logic                                  ready;
  logic [sosc_pkg::NOTE_W-1:0]           note_frequency;
  logic signed [sosc_pkg::OFFSET_W-1:0]  frequency_offset;
  logic                                  gate;

  modport source (output valid, note_frequency, frequency_offset, gate, input ready);
  modport sink   (input valid, note_frequency, frequency_offset, gate, output ready);
endinterface

interface sosc_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sosc_pkg::SAMPLE_W-1:0]  left_sample;
  logic signed [sosc_pkg::SAMPLE_W-1:0]  right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

`default_nettype wire

// ===== design/sosc_sine_rom.sv =====
// Quarter-wave sine ROM with a registered read.
// Depends on sosc_pkg (table builder, widths).
`default_nettype none

module sosc_sine_rom (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [sosc_pkg::SINE_TABLE_BITS-1:0] addr,
  output logic      [sosc_pkg::SINE_W-1:0]          data
);

  localparam sosc_pkg::sine_rom_t SINE_ROM = sosc_pkg::build_sine_table();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= SINE_ROM[addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sosc_front.sv =====
// Front of the pipeline: tick capture and clamp, phase increment multiply,
// phase and amplitude update with the sine ROM read. Depends on sosc_pkg,
// sosc_if and sosc_sine_rom.
`default_nettype none

module sosc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  sosc_tick_if.sink          tick,
  input  wire sosc_pkg::cfg_t cfg,
  output sosc_pkg::stage_c_t stage_c,
  input  wire logic          c_ready
);

  localparam int PB = sosc_pkg::PHASE_BITS;
  localparam int TB = sosc_pkg::SINE_TABLE_BITS;

  // stage A: clamped frequency
  logic                        va;
  logic [sosc_pkg::NOTE_W-1:0] fa;
  logic                        ga;
  // stage B: phase increment
  logic                        vb;
  logic [PB-1:0]               inc;
  logic                        gb;
  // state
  logic [PB-1:0]               phase;
  logic [sosc_pkg::AMP_W-1:0]  amp;
  // stage C
  logic                        vc;
  logic                        negc;
  logic [sosc_pkg::AMP_W-1:0]  ampc;
  logic [sosc_pkg::SINE_W-1:0] rom_data;

  logic a_free, b_free, c_free, move_bc;

  logic signed [sosc_pkg::NOTE_W+1:0] fsum;
  logic [sosc_pkg::NOTE_W-1:0]        fclamp;
  logic [sosc_pkg::PROD_W-1:0]        prod;
  logic [sosc_pkg::PROD_W+PB-1:0]     inc_wide;
  logic [1:0]                         quad;
  logic [TB-1:0]                      rom_addr;
  logic [sosc_pkg::AMP_W:0]           amp_up, amp_sel;
  logic [sosc_pkg::AMP_W-1:0]         amp_next;

  assign c_free     = !vc || c_ready;
  assign move_bc    = vb && c_free;
  assign b_free     = !vb || c_free;
  assign a_free     = !va || b_free;
  assign tick.ready = a_free;

  always_comb begin
    fsum = $signed({2'b00, tick.note_frequency})
         + (sosc_pkg::NOTE_W+2)'(tick.frequency_offset);
    if (fsum < $signed({2'b00, sosc_pkg::FREQ_MIN})) begin
      fclamp = sosc_pkg::FREQ_MIN;
    end else if (fsum > $signed({2'b00, sosc_pkg::FREQ_MAX})) begin
      fclamp = sosc_pkg::FREQ_MAX;
    end else begin
      fclamp = fsum[sosc_pkg::NOTE_W-1:0];
    end
  end

  always_comb begin
    prod     = sosc_pkg::PROD_W'(fa) * sosc_pkg::PROD_W'(cfg.phase_step);
    inc_wide = ({{PB{1'b0}}, prod} >> sosc_pkg::RSHIFT) << sosc_pkg::LSHIFT;
  end

  // quadrants 1 and 3 read the table mirrored
  always_comb begin
    quad     = phase[PB-1 -: 2];
    rom_addr = quad[0] ? ~phase[PB-3 -: TB] : phase[PB-3 -: TB];
  end

  always_comb begin
    amp_up = {1'b0, amp} + (sosc_pkg::AMP_W+1)'(cfg.amp_step);
    if (gb) begin
      amp_sel = amp_up;
    end else if (amp >= sosc_pkg::AMP_W'(cfg.amp_step)) begin
      amp_sel = {1'b0, amp - sosc_pkg::AMP_W'(cfg.amp_step)};
    end else begin
      amp_sel = '0;
    end
    if (amp_sel > {1'b0, cfg.amp_limit}) begin
      amp_next = cfg.amp_limit;
    end else begin
      amp_next = amp_sel[sosc_pkg::AMP_W-1:0];
    end
  end

  sosc_sine_rom u_rom (
    .clk  (clk),
    .en   (move_bc),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vc    <= 1'b0;
      phase <= '0;
      amp   <= '0;
    end else begin
      if (a_free) begin
        va <= tick.valid;
      end
      if (b_free) begin
        vb <= va;
      end
      if (c_free) begin
        vc <= vb;
      end
      if (move_bc) begin
        phase <= phase + inc;
        amp   <= amp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && tick.valid) begin
      fa <= fclamp;
      ga <= tick.gate;
    end
    if (b_free && va) begin
      inc <= inc_wide[PB-1:0];
      gb  <= ga;
    end
    if (move_bc) begin
      negc <= quad[1];
      ampc <= amp_next;
    end
  end

  assign stage_c.valid = vc;
  assign stage_c.neg   = negc;
  assign stage_c.sine  = rom_data;
  assign stage_c.amp   = ampc;

endmodule

`default_nettype wire

// ===== design/sosc_scale.sv =====
// Back of the pipeline: sine times amplitude, rounding and the output register.
// Depends on sosc_pkg and sosc_if.
`default_nettype none

module sosc_scale (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sosc_pkg::stage_c_t stage_c,
  output logic                   c_ready,
  sosc_sample_if.source          result
);

  logic                          vd;
  logic                          negd;
  logic [sosc_pkg::MAG_W-1:0]    magd;
  logic                          ov;
  logic signed [sosc_pkg::SAMPLE_W-1:0] sample;

  logic                          d_free, out_free;
  logic [sosc_pkg::MAG_W:0]      rounded;
  logic [sosc_pkg::SAMPLE_W-1:0] r;

  assign out_free = !ov || result.ready;
  assign d_free   = !vd || out_free;
  assign c_ready  = d_free;

  // round half away from zero on the magnitude, then apply the sign
  always_comb begin
    rounded = {1'b0, magd} + ((sosc_pkg::MAG_W+1)'(1) << 23);
    r       = rounded[24 +: sosc_pkg::SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (d_free) begin
        vd <= stage_c.valid;
      end
      if (out_free) begin
        ov <= vd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_free && stage_c.valid) begin
      magd <= sosc_pkg::MAG_W'(stage_c.sine) * sosc_pkg::MAG_W'(stage_c.amp);
      negd <= stage_c.neg;
    end
    if (out_free && vd) begin
      sample <= negd ? -$signed(r) : $signed(r);
    end
  end

  assign result.valid        = ov;
  assign result.left_sample  = sample;
  assign result.right_sample = sample;

endmodule

`default_nettype wire

// ===== design/sine_oscillator_with_amplitude_ramp_core.sv =====
// Top level of the sine oscillator with amplitude ramp: config registers and
// the two pipeline halves. Depends on sosc_pkg, sosc_if, sosc_front, sosc_scale.
//
//   channel  | dir | word
//   ---------+-----+-----------------------------------------------
//   tick     | in  | note_frequency, frequency_offset, gate
//   result   | out | left_sample, right_sample
//   config   | in  | config_write, config_index, config_data
//
// One tick per cycle sustained while the result sink keeps ready high; a taken tick
// passes through registered steps in order (clamp, increment multiply, ROM read with
// phase/amplitude update, sine-amplitude multiply, round into the output register).
// Reset clears phase, amplitude and all valid flags and reloads the register
// defaults; the sine ROM is constant and needs no fill.
// Each stage moves into a free slot, so a stalled result holds up to five words.
`default_nettype none

module sine_oscillator_with_amplitude_ramp_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  sosc_tick_if.sink                              tick,
  sosc_sample_if.source                          result,
  input  wire logic                              config_write,
  input  wire logic [sosc_pkg::CFG_INDEX_W-1:0]  config_index,
  input  wire logic [sosc_pkg::CFG_W-1:0]        config_data
);

  sosc_pkg::cfg_t     cfg;
  sosc_pkg::stage_c_t stage_c;
  logic               c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= sosc_pkg::RESET_PHASE_STEP;
      cfg.amp_step   <= sosc_pkg::RESET_AMP_STEP;
      cfg.amp_limit  <= sosc_pkg::RESET_AMP_LIMIT;
    end else if (config_write) begin
      case (config_index)
        sosc_pkg::REG_PHASE_STEP: cfg.phase_step <= config_data;
        sosc_pkg::REG_AMP_STEP:   cfg.amp_step   <= config_data[sosc_pkg::AMP_STEP_W-1:0];
        sosc_pkg::REG_AMP_LIMIT:  cfg.amp_limit  <= config_data;
        default: ;
      endcase
    end
  end

  sosc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .cfg     (cfg),
    .stage_c (stage_c),
    .c_ready (c_ready)
  );

  sosc_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .stage_c (stage_c),
    .c_ready (c_ready),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== design/sosc_checker.sv =====
// Port-level checker for the oscillator core, bound to the top level.
// Depends on sosc_pkg and the top level's ports.
`default_nettype none

module sosc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                result_valid,
  input wire logic                                result_ready,
  input wire logic signed [sosc_pkg::SAMPLE_W-1:0] left_sample,
  input wire logic signed [sosc_pkg::SAMPLE_W-1:0] right_sample
);

  // both channels carry the same word
  a_stereo_equal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> left_sample == right_sample)
    else $error("left and right samples differ");

  // magnitude never exceeds full scale, so the most negative code cannot occur
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> left_sample != 16'sh8000)
    else $error("sample out of symmetric range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present straight after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(left_sample))
    else $error("result word changed while stalled");

endmodule

bind sine_oscillator_with_amplitude_ramp_core sosc_checker u_sosc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .left_sample  (result.left_sample),
  .right_sample (result.right_sample)
);

`default_nettype wire

// ===== bench/sine_oscillator_with_amplitude_ramp_core_tb.sv =====
// Self-checking bench for sine_oscillator_with_amplitude_ramp_core: a table of directed
// ticks, then random gate runs across several register settings, checked against a
// behavioural oscillator. Depends on sosc_pkg, sosc_if and the core.
`default_nettype none

module sine_oscillator_with_amplitude_ramp_core_tb;
  import sosc_pkg::*;

  localparam int PHASE_COUNT   = 8;
  localparam int RANDOM_TICKS  = 205;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LONG_HOLD     = 60;
  localparam int LOWEST_FREQ   = 320;
  localparam int HIGHEST_FREQ  = 320000;
  localparam int DIRECTED_ROWS = 25;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [NOTE_W-1:0]          note;
    logic signed [OFFSET_W-1:0] offs;
    logic                       gate;
    logic                       known;
    logic signed [SAMPLE_W-1:0] want;
  } tick_row_t;

  typedef struct {
    logic [PHASE_STEP_W-1:0] phase_step;
    logic [AMP_STEP_W-1:0]   amp_step;
    logic [AMP_W-1:0]        amp_limit;
    logic                    draw;
  } setting_row_t;

  logic clk;
  logic rst;
  logic config_write;
  logic [CFG_INDEX_W-1:0] config_index;
  logic [CFG_W-1:0] config_data;

  sosc_tick_if   tick ();
  sosc_sample_if result ();

  sine_oscillator_with_amplitude_ramp_core dut (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .result       (result),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data)
  );

  // oscillator state mirrored by the bench
  logic [SINE_W-1:0]       sine_lut [TABLE_SIZE];
  logic [PHASE_BITS-1:0]   phase_acc;
  logic [AMP_W-1:0]        amp_level;
  logic [PHASE_STEP_W-1:0] phase_step_cfg;
  logic [AMP_STEP_W-1:0]   amp_step_cfg;
  logic [AMP_W-1:0]        amp_limit_cfg;

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_pending;

  tick_row_t directed [DIRECTED_ROWS] = '{
    '{0,      -8000, 0, 1, 0},  // negative sum, amplitude still zero
    '{320000,  8000, 0, 1, 0},  // clamps high
    '{0,          0, 0, 1, 0},
    '{319,        0, 0, 1, 0},
    '{320,        0, 1, 0, 0},
    '{320000,     0, 1, 0, 0},
    '{319999,     1, 1, 0, 0},
    '{7000,   -8000, 1, 0, 0},
    '{0,       8000, 1, 0, 0},
    '{400,      -81, 1, 0, 0},
    '{262144,    -1, 1, 0, 0},
    '{131071,  5461, 1, 0, 0},
    '{174762, -5462, 1, 0, 0},
    '{87381,      1, 1, 0, 0},
    '{320000,    -1, 0, 0, 0},
    '{300000,  8000, 0, 0, 0},
    '{12345,  -1234, 0, 0, 0},
    '{160000,     0, 0, 0, 0},
    '{320000,  8000, 0, 0, 0},
    '{240000, -8000, 0, 0, 0},
    '{99999,   4096, 0, 0, 0},
    '{200000,  -100, 0, 0, 0},
    '{320000,     0, 0, 0, 0},  // one step left
    '{310000,  2222, 0, 0, 0},  // amplitude back at zero
    '{5000,    7999, 0, 0, 0}   // ramp held at zero
  };

  setting_row_t settings [PHASE_COUNT] = '{
    '{RESET_PHASE_STEP, RESET_AMP_STEP, RESET_AMP_LIMIT, 0},
    '{24'hFFFFFF, 20'hFFFFF, 24'hFFFFFF, 0},
    '{24'h000000, 20'h08000, 24'h100000, 0},  // phase frozen
    '{RESET_PHASE_STEP, 20'h00000, 24'hC00000, 0},
    '{24'h123456, 20'hFFFFF, 24'h000000, 0},
    '{24'h000000, 20'h00000, 24'h000000, 1},
    '{24'h000000, 20'h00000, 24'hFFFFFF, 1},
    '{RESET_PHASE_STEP, RESET_AMP_STEP, RESET_AMP_LIMIT, 0}
  };

  function automatic void fill_sine_lut();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] q15;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      x    = (64'(2 * k + 1) * HALF_PI_Q30) / 64'(2 * TABLE_SIZE);
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = (acc >= term) ? acc - term : 64'd0;
        else acc = acc + term;
      end
      q15 = (acc + 64'd16384) >> 15;
      sine_lut[k] = (q15 > 64'd32767) ? 16'd32767 : q15[SINE_W-1:0];
    end
  endfunction

  // one sample tick: sine of the current phase times the ramped amplitude
  function automatic logic signed [SAMPLE_W-1:0] next_sample(
    input logic [NOTE_W-1:0] note, input logic signed [OFFSET_W-1:0] offs, input logic g);
    int f;
    logic [PROD_W-1:0] prod;
    logic [1:0] quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_W-1:0] sine_mag;
    logic [AMP_W:0] amp_next;
    logic [MAG_W-1:0] mag;
    logic [SAMPLE_W-1:0] r;
    f = int'(note) + int'(offs);
    if (f < LOWEST_FREQ) f = LOWEST_FREQ;
    if (f > HIGHEST_FREQ) f = HIGHEST_FREQ;
    prod = PROD_W'(f) * PROD_W'(phase_step_cfg);

    quad = phase_acc[PHASE_BITS-1 -: 2];
    idx  = phase_acc[PHASE_BITS-3 -: SINE_TABLE_BITS];
    if (quad[0]) idx = SINE_TABLE_BITS'(TABLE_SIZE - 1) - idx;
    sine_mag  = sine_lut[idx];
    phase_acc = phase_acc + PHASE_BITS'(prod >> RSHIFT);

    if (g) amp_next = {1'b0, amp_level} + (AMP_W + 1)'(amp_step_cfg);
    else amp_next = (amp_level >= amp_step_cfg) ? {1'b0, amp_level - AMP_W'(amp_step_cfg)} : '0;
    if (amp_next > amp_limit_cfg) amp_next = {1'b0, amp_limit_cfg};
    amp_level = amp_next[AMP_W-1:0];

    mag = MAG_W'(sine_mag) * MAG_W'(amp_level);
    r   = SAMPLE_W'((mag + MAG_W'(1 << 23)) >> 24);
    return quad[1] ? -r : r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("sine_oscillator_with_amplitude_ramp_core_tb: errors");
    $finish;
  end

  task automatic check_sample();
    logic signed [SAMPLE_W-1:0] want;
    if (expected_samples.size() == 0) begin
      $error("unexpected sample word: left_sample %0d", result.left_sample);
      errors++;
    end else begin
      want = expected_samples.pop_front();
      if (result.left_sample !== want) begin
        $error("left_sample: expected %0d, got %0d", want, result.left_sample);
        errors++;
      end
      if (result.right_sample !== want) begin
        $error("right_sample: expected %0d, got %0d", want, result.right_sample);
        errors++;
      end
    end
  endtask

  // sample sink: random stalls, plus one long hold-off on request
  initial begin : sample_sink
    int hold_left;
    hold_left = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) check_sample();
      @(negedge clk);
      if (hold_left > 0) begin
        result.ready = 1'b0;
        hold_left--;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = LONG_HOLD;
        result.ready = 1'b0;
      end else begin
        result.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_tick(input logic [NOTE_W-1:0] note, input logic signed [OFFSET_W-1:0] offs,
                           input logic g, input logic known, input logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      tick.valid = 1'b0;
      @(negedge clk);
    end
    tick.valid            = 1'b1;
    tick.note_frequency   = note;
    tick.frequency_offset = offs;
    tick.gate             = g;
    do @(posedge clk); while (!tick.ready);
    predicted = next_sample(note, offs, g);
    expected_samples.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    config_write = 1'b1;
    config_index = idx;
    config_data  = val;
    @(negedge clk);
    config_write = 1'b0;
    case (idx)
      REG_PHASE_STEP: phase_step_cfg = val[PHASE_STEP_W-1:0];
      REG_AMP_STEP:   amp_step_cfg   = val[AMP_STEP_W-1:0];
      REG_AMP_LIMIT:  amp_limit_cfg  = val[AMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    tick.valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly key-press runs of one gate level; some ticks flip the gate at random
  task automatic run_random(input int count);
    int run_left;
    int pick;
    logic level;
    logic g;
    logic [NOTE_W-1:0] n;
    int o;
    run_left = 0;
    level = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        level = ~level;
        run_left = $urandom_range(1, 60);
      end
      run_left--;
      g = ($urandom_range(99) < 12) ? 1'($urandom) : level;
      pick = $urandom_range(99);
      if (pick < 10) n = NOTE_W'($urandom_range(1000));
      else if (pick < 20) n = NOTE_W'($urandom_range(320000, 319000));
      else n = NOTE_W'($urandom_range(320000));
      o = int'($urandom_range(16000)) - 8000;
      send_tick(n, OFFSET_W'(o), g, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    setting_row_t s;
    rst                   = 1'b1;
    tick.valid            = 1'b0;
    tick.note_frequency   = '0;
    tick.frequency_offset = '0;
    tick.gate             = 1'b0;
    config_write          = 1'b0;
    config_index          = REG_PHASE_STEP;
    config_data           = '0;
    errors                = 0;
    hold_pending          = 1'b0;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    fill_sine_lut();
    phase_acc      = '0;
    amp_level      = '0;
    phase_step_cfg = RESET_PHASE_STEP;
    amp_step_cfg   = RESET_AMP_STEP;
    amp_limit_cfg  = RESET_AMP_LIMIT;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 3)
        0: begin send_idle_pct = 31; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p > 0) begin
        s = settings[p];
        if (s.draw) begin
          s.phase_step = PHASE_STEP_W'($urandom);
          s.amp_step   = AMP_STEP_W'($urandom_range(20'hFFFFF, 20'h10000));
          if (s.amp_limit == '0) s.amp_limit = AMP_W'($urandom);
        end
        drain();
        write_reg(REG_PHASE_STEP, CFG_W'(s.phase_step));
        write_reg(REG_AMP_STEP, CFG_W'(s.amp_step));
        write_reg(REG_AMP_LIMIT, CFG_W'(s.amp_limit));
        if (p == 1) write_reg(REG_UNUSED, 24'hFFFFFF);  // no such register
      end
      if (p == 0) begin
        foreach (directed[i])
          send_tick(directed[i].note, directed[i].offs, directed[i].gate,
                    directed[i].known, directed[i].want);
      end
      if (p == 1) hold_pending = 1'b1;  // let the core fill up behind a stalled sink
      run_random(RANDOM_TICKS);
    end

    drain();
    if (errors == 0) begin
      $display("sine_oscillator_with_amplitude_ramp_core_tb: clean");
    end else begin
      $display("sine_oscillator_with_amplitude_ramp_core_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
